/* sv/md5_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round helper functions for the MD5 stream core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WordW  = 32;
    localparam int CountW = 61;

    // initial chaining value
    localparam logic [WordW-1:0] IV_A = 32'h67452301;
    localparam logic [WordW-1:0] IV_B = 32'hefcdab89;
    localparam logic [WordW-1:0] IV_C = 32'h98badcfe;
    localparam logic [WordW-1:0] IV_D = 32'h10325476;

    // pad marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_byte;   // store one message byte and bump the count
        logic pad;         // 0x80, zero fill and (if room) the bit length
        logic len;         // extra block: zeros and the bit length
        logic prep;        // load working regs, prefetch first round operand
        logic round;       // one compression round
        logic add;         // fold working regs into the chaining value
        logic load_out;    // move digest to output and restart the message
    } md5_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic pos_full;    // next byte fills the block
        logic pos_two;     // no room for the length after the pad byte
        logic round_last;  // current round is the 64th
        logic out_empty;   // output holding register drained
    } md5_stat_t;

    // additive constants
    function automatic logic [WordW-1:0] md5_k(input logic [5:0] r);
        logic [WordW-1:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // per-round left rotate amount
    function automatic logic [4:0] md5_rot(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used in each round
    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0: g = lo;
            2'd1: g = 4'((lo << 2) + lo + 4'd1);
            2'd2: g = 4'((lo << 1) + lo + 4'd5);
            2'd3: g = 4'((lo << 3) - lo);
            default: g = lo;
        endcase
        return g;
    endfunction

    // rotate left by 0..31
    function automatic logic [WordW-1:0] md5_rotl(input logic [WordW-1:0] x,
                                                  input logic [4:0] s);
        logic [2*WordW-1:0] t;
        t = {x, x} << s;
        return t[2*WordW-1:WordW];
    endfunction

endpackage

/* sv/md5_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, padding steps, compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
module md5_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               byte_valid,
    input  logic               last,
    input  md5_pkg::md5_stat_t stat,
    output md5_pkg::md5_cmd_t  cmd
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_WAIT_OUT
    } state_t;

    state_t state_reg;
    logic   fin_reg;       // message end seen, padding in progress
    logic   need_len_reg;  // length goes into a block of its own
    logic   final_reg;     // running compression is the last one
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // command decode
    always_comb begin
        cmd           = '0;
        cmd.take_byte = accept && byte_valid;
        cmd.prep      = (state_reg == ST_PREP);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.add       = (state_reg == ST_ADD);
        cmd.pad       = (state_reg == ST_PAD);
        cmd.len       = (state_reg == ST_LEN);
        cmd.load_out  = (state_reg == ST_WAIT_OUT) && stat.out_empty;
    end

    // state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fin_reg      <= 1'b0;
            need_len_reg <= 1'b0;
            final_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (byte_valid && stat.pos_full) begin
                            state_reg <= ST_PREP;
                            fin_reg   <= last;
                        end else if (last) begin
                            state_reg <= ST_PAD;
                            fin_reg   <= 1'b1;
                        end
                    end
                end
                ST_PREP: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (stat.round_last) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (!fin_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (final_reg) begin
                        state_reg <= ST_WAIT_OUT;
                    end else if (need_len_reg) begin
                        state_reg <= ST_LEN;
                    end else begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    state_reg    <= ST_PREP;
                    need_len_reg <= stat.pos_two;
                    final_reg    <= !stat.pos_two;
                end
                ST_LEN: begin
                    state_reg    <= ST_PREP;
                    need_len_reg <= 1'b0;
                    final_reg    <= 1'b1;
                end
                ST_WAIT_OUT: begin
                    if (stat.out_empty) begin
                        state_reg    <= ST_IDLE;
                        fin_reg      <= 1'b0;
                        need_len_reg <= 1'b0;
                        final_reg    <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/md5_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_dpath
// Block buffer, byte count, round unit, chaining value and digest output.
// ----------------------------------------------------------------------------
module md5_dpath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  md5_pkg::md5_cmd_t          cmd,
    output md5_pkg::md5_stat_t         stat,
    input  logic [7:0]                 data_byte,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [md5_pkg::WordW-1:0]  m_tdata,
    output logic                       m_tlast
);
    import md5_pkg::*;

    logic [WordW-1:0]  buf_reg [16];
    logic [WordW-1:0]  cv_reg  [4];
    logic [WordW-1:0]  rr_reg  [4];
    logic [WordW-1:0]  out_reg [4];
    logic [2:0]        out_cnt_reg;
    logic [CountW-1:0] cnt_reg;
    logic [5:0]        r_reg;
    logic [WordW-1:0]  km_reg;

    logic [5:0]        pos;
    logic [3:0]        cur_w;
    logic [1:0]        lane;
    logic [WordW-1:0]  len_lo;
    logic [WordW-1:0]  len_hi;
    logic [WordW-1:0]  fval;
    logic [WordW-1:0]  sum;
    logic [WordW-1:0]  new_b;
    logic [5:0]        r_next;
    logic [WordW-1:0]  pad_word;
    logic              out_take;

    assign pos    = cnt_reg[5:0];
    assign cur_w  = pos[5:2];
    assign lane   = pos[1:0];
    assign len_lo = {cnt_reg[28:0], 3'b000};
    assign len_hi = cnt_reg[60:29];

    // status
    assign stat.pos_full   = (pos == 6'd63);
    assign stat.pos_two    = (pos[5:3] == 3'd7);
    assign stat.round_last = (r_reg == 6'd63);
    assign stat.out_empty  = (out_cnt_reg == 3'd0);

    // word holding the pad byte: lower lanes kept, marker, zeros above
    always_comb begin
        pad_word = buf_reg[cur_w];
        for (int j = 0; j < 4; j++) begin
            if (2'(j) == lane) begin
                pad_word[8*j +: 8] = PAD_BYTE;
            end else if (2'(j) > lane) begin
                pad_word[8*j +: 8] = 8'h00;
            end
        end
    end

    // round function
    always_comb begin
        unique case (r_reg[5:4])
            2'd0: fval = (rr_reg[1] & rr_reg[2]) | (~rr_reg[1] & rr_reg[3]);
            2'd1: fval = (rr_reg[1] & rr_reg[3]) | (rr_reg[2] & ~rr_reg[3]);
            2'd2: fval = rr_reg[1] ^ rr_reg[2] ^ rr_reg[3];
            2'd3: fval = rr_reg[2] ^ (rr_reg[1] | ~rr_reg[3]);
            default: fval = '0;
        endcase
    end

    assign sum    = rr_reg[0] + fval + km_reg;
    assign new_b  = rr_reg[1] + md5_rotl(sum, md5_rot(r_reg));
    assign r_next = r_reg + 6'd1;

    // block buffer
    always_ff @(posedge aclk) begin
        if (cmd.take_byte) begin
            buf_reg[cur_w][8*lane +: 8] <= data_byte;
        end else if (cmd.pad) begin
            // length words are zeroed here only when the length needs its own block
            for (int w = 0; w < 16; w++) begin
                if (4'(w) == cur_w) begin
                    buf_reg[w] <= pad_word;
                end else if (4'(w) > cur_w && (w < 14 || stat.pos_two)) begin
                    buf_reg[w] <= '0;
                end
            end
            if (!stat.pos_two) begin
                buf_reg[14] <= len_lo;
                buf_reg[15] <= len_hi;
            end
        end else if (cmd.len) begin
            for (int w = 0; w < 14; w++) begin
                buf_reg[w] <= '0;
            end
            buf_reg[14] <= len_lo;
            buf_reg[15] <= len_hi;
        end
    end

    // round operand prefetch
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            km_reg <= md5_k(6'd0) + buf_reg[md5_g(6'd0)];
        end else if (cmd.round) begin
            km_reg <= md5_k(r_next) + buf_reg[md5_g(r_next)];
        end
    end

    // byte count, round index, working and chaining registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            r_reg   <= '0;
            cv_reg  <= '{IV_A, IV_B, IV_C, IV_D};
            rr_reg  <= '{default: '0};
        end else begin
            if (cmd.take_byte) begin
                cnt_reg <= cnt_reg + CountW'(1);
            end else if (cmd.load_out) begin
                cnt_reg <= '0;
            end
            if (cmd.prep) begin
                r_reg  <= '0;
                rr_reg <= cv_reg;
            end else if (cmd.round) begin
                r_reg     <= r_next;
                rr_reg[0] <= rr_reg[3];
                rr_reg[1] <= new_b;
                rr_reg[2] <= rr_reg[1];
                rr_reg[3] <= rr_reg[2];
            end
            if (cmd.add) begin
                for (int i = 0; i < 4; i++) begin
                    cv_reg[i] <= cv_reg[i] + rr_reg[i];
                end
            end else if (cmd.load_out) begin
                cv_reg <= '{IV_A, IV_B, IV_C, IV_D};
            end
        end
    end

    // digest output shift register
    assign out_take = m_tvalid && m_tready;
    assign m_tvalid = (out_cnt_reg != 3'd0);
    assign m_tdata  = out_reg[0];
    assign m_tlast  = (out_cnt_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= '0;
        end else if (cmd.load_out) begin
            out_cnt_reg <= 3'd4;
        end else if (out_take) begin
            out_cnt_reg <= out_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= cv_reg;
        end else if (out_take) begin
            out_reg[0] <= out_reg[1];
            out_reg[1] <= out_reg[2];
            out_reg[2] <= out_reg[3];
        end
    end

endmodule

/* sv/md5_digest_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_digest_stream
// MD5 hash over a byte stream; emits the four digest words per message.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                  | tuser          | tlast
//  s_      | in        | [7:0] data_byte        | [0] byte_valid | last
//  m_      | out       | [31:0] digest_word A-D | -              | word_last
//
//  a message byte is accepted only while idle; a full block then holds the input
//  through operand prefetch, 64 rounds of the single round unit and the fold
//  a closing item adds a pad step and one compression, or with no room for the
//  length also a length step and a second compression; then the digest load
//  bytes of the next message are taken while the digest drains on m_
//  aresetn is synchronous; it restores the initial chaining value
// ----------------------------------------------------------------------------
module md5_digest_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast
);
    import md5_pkg::*;

    md5_cmd_t  cmd;
    md5_stat_t stat;

    // sequencer
    md5_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .byte_valid (s_tuser[0]),
        .last       (s_tlast),
        .stat       (stat),
        .cmd        (cmd)
    );

    // hash datapath
    md5_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .data_byte (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // no input item while the round unit runs
    a_no_accept_in_round: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round |-> !s_tready)
        else $error("input accepted during compression");

    // digest only loaded into an empty output register
    a_load_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_empty)
        else $error("digest overwrote pending output");

    // a loaded digest is offered on the next cycle with word A
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (m_tvalid && !m_tlast))
        else $error("digest not presented after load");

    // a byte is stored only on an accepted item
    a_take_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_byte |-> (s_tvalid && s_tready && s_tuser[0]))
        else $error("byte stored without accepted item");
`endif

endmodule

/* bench/tb_md5_digest_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_digest_stream
// Self-checking bench for the byte-stream MD5 core. A short table of directed
// items covers empty messages, single bytes, ignored items and both ways of
// closing a message. Random messages follow, lengths clustered near the block
// and pad boundaries. Each word on m_ is checked against an in-bench MD5 model
// or the typed-in empty digest; later phases idle and stall channels at random.
// ----------------------------------------------------------------------------
module tb_md5_digest_stream;

    import md5_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RAND_ITEMS   = 296;
    localparam int TAIL_CYCLES  = 200;
    localparam int MAX_REPORTS  = 10;

    // digest of the empty string, as words a to d
    localparam logic [31:0] EMPTY_DIGEST [4] = '{
        32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec
    };

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // one directed item; known_empty selects the typed-in empty digest
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       msg_last;
        logic       known_empty;
    } stim_row_t;

    localparam int DIR_ROWS = 14;
    localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{8'hff, 1'b0, 1'b0, 1'b0},   // ignored item, all-ones data
        '{8'h00, 1'b0, 1'b1, 1'b1},   // empty message, first close after reset
        '{8'h00, 1'b0, 1'b0, 1'b0},   // ignored item, all-zero data
        '{8'hff, 1'b0, 1'b1, 1'b1},   // empty message again, data ignored
        '{8'h00, 1'b1, 1'b1, 1'b0},   // one zero byte closing the message
        '{8'hff, 1'b1, 1'b1, 1'b0},   // one all-ones byte closing the message
        '{8'h61, 1'b1, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0},   // ignored item inside a message
        '{8'h62, 1'b1, 1'b0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 1'b0},
        '{8'h55, 1'b1, 1'b0, 1'b0},
        '{8'haa, 1'b1, 1'b0, 1'b0},
        '{8'h0f, 1'b0, 1'b1, 1'b0},   // close without a byte after data
        '{8'hf0, 1'b1, 1'b1, 1'b0}
    };

    typedef struct {
        logic [31:0] word;
        logic        word_last;
    } digest_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic [0:0]  s_tuser  = '0;   // [0] byte_valid
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] digest_word
    logic        m_tlast;

    // bench copy of the hash state
    logic [31:0] digest_chain [4];
    logic [31:0] msg_words [16];
    logic [60:0] msg_len;

    digest_beat_t expected_digest [$];
    int unsigned  err_count   = 0;
    int unsigned  items_sent  = 0;
    int unsigned  send_idle   = 0;
    int unsigned  recv_stall  = 0;

    md5_digest_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // restart the chaining value and length for a new message
    function automatic void start_message();
        digest_chain[0] = IV_A;
        digest_chain[1] = IV_B;
        digest_chain[2] = IV_C;
        digest_chain[3] = IV_D;
        msg_len = '0;
    endfunction

    function automatic void store_byte(int unsigned pos, logic [7:0] v);
        msg_words[(pos >> 2) & 15][(pos & 3) * 8 +: 8] = v;
    endfunction

    function automatic logic [31:0] rotate_left(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // one 64-round block compression folded into the chaining value
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, sum;
        int          g;
        a = digest_chain[0];
        b = digest_chain[1];
        c = digest_chain[2];
        d = digest_chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r >> 4)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) & 15;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) & 15;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) & 15;
                end
            endcase
            sum = a + f + SINE_K[r] + msg_words[g];
            a = d;
            d = c;
            c = b;
            b = b + rotate_left(sum, ROT_AMT[((r >> 4) << 2) | (r & 3)]);
        end
        digest_chain[0] += a;
        digest_chain[1] += b;
        digest_chain[2] += c;
        digest_chain[3] += d;
    endfunction

    // update the hash for one accepted item, queue digest words on a close
    function automatic void hash_item(logic [7:0] data, logic byte_valid,
                                      logic msg_last, logic known_empty);
        int unsigned pos;
        logic [63:0] bit_len;
        if (byte_valid) begin
            pos = 32'(msg_len[5:0]);
            store_byte(pos, data);
            msg_len = msg_len + 61'd1;
            if (pos == 63) compress_block();
        end
        if (msg_last) begin
            pos = 32'(msg_len[5:0]);
            bit_len = {msg_len, 3'b000};
            store_byte(pos, PAD_BYTE);
            pos++;
            // pad byte leaves no room for the length: one extra block
            if (pos > 56) begin
                while (pos < 64) begin
                    store_byte(pos, 8'h00);
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                store_byte(pos, 8'h00);
                pos++;
            end
            msg_words[14] = bit_len[31:0];
            msg_words[15] = bit_len[63:32];
            compress_block();
            for (int n = 0; n < 4; n++) begin
                expected_digest.push_back('{known_empty ? EMPTY_DIGEST[n] : digest_chain[n],
                                            n == 3});
            end
            start_message();
        end
    endfunction

    // drive one item and wait for its handshake
    task automatic send_item(logic [7:0] data, logic byte_valid, logic msg_last,
                             logic known_empty);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= byte_valid;
        s_tlast  <= msg_last;
        do @(posedge aclk); while (!s_tready);
        hash_item(data, byte_valid, msg_last, known_empty);
        items_sent++;
    endtask

    // stop sending until every queued digest word has come back
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_digest.size() != 0);
    endtask

    // random message; lengths cluster near the pad and block boundaries
    task automatic send_message(int unsigned budget);
        int unsigned pick, msg_bytes;
        logic        close_apart;
        pick = $urandom_range(99);
        if (pick < 45)      msg_bytes = $urandom_range(8);
        else if (pick < 75) msg_bytes = $urandom_range(70, 52);
        else if (pick < 90) msg_bytes = $urandom_range(130, 112);
        else                msg_bytes = $urandom_range(200);
        // cap the byte count below the remaining item budget
        if (msg_bytes >= budget) msg_bytes = budget - 1;
        close_apart = (msg_bytes == 0) || $urandom_range(1);
        for (int unsigned i = 0; i < msg_bytes; i++) begin
            if ($urandom_range(99) < 5)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1,
                      !close_apart && (i == msg_bytes - 1), 1'b0);
        end
        if (close_apart) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
    endtask

    // result channel: random stall, compare each word against the queue
    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_digest.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected digest word %h last %0b", m_tdata, m_tlast);
            end else begin
                want = expected_digest.pop_front();
                if (m_tdata !== want.word || m_tlast !== want.word_last) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("digest word mismatch: expected %h last %0b, got %h last %0b",
                                 want.word, want.word_last, m_tdata, m_tlast);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // main sequence
    initial begin
        int unsigned rand_base, phase, last_phase;
        start_message();
        for (int n = 0; n < 16; n++) msg_words[n] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].byte_valid,
                      DIRECTED_ROWS[i].msg_last, DIRECTED_ROWS[i].known_empty);
        end
        drain_pause();

        // random messages over four idling phases
        rand_base  = items_sent;
        last_phase = 0;
        while (items_sent - rand_base < RAND_ITEMS) begin
            phase = ((items_sent - rand_base) * 4) / RAND_ITEMS;
            if (phase > 3) phase = 3;
            if (phase != last_phase) begin
                drain_pause();
                last_phase = phase;
            end
            case (phase)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 60;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 60;
                end
                default: begin
                    send_idle  = 38;
                    recv_stall = 38;
                end
            endcase
            send_message(RAND_ITEMS - (items_sent - rand_base));
        end

        // drain and let the core settle
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_digest.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0 && expected_digest.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
